// ===== rtl/lped_pkg.sv =====
`default_nettype none

package lped_pkg;

  localparam logic [7:0] FLAG_BYTE   = 8'h7d;
  localparam logic [7:0] ESC_BYTE    = 8'h7e;
  localparam logic [7:0] ESC_XOR     = 8'h20;
  localparam logic [7:0] MAX_LEN_RST = 8'hff;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_DROP = 2'd2
  } kind_t;

  // One decoded result, with a flag that says whether the byte produced one.
  typedef struct packed {
    logic       has_result;
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] position;
    logic [7:0] frame_length;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/lped_decode.sv =====
`default_nettype none

module lped_decode (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      rx_byte,
  input  wire logic [7:0]      max_len,
  output lped_pkg::result_t    res
);

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_LEN     = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_ESC     = 3'd3,
    PH_END     = 3'd4
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] expected_len, expected_len_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] count_inc;
  logic [7:0] payload;

  assign count_inc = byte_count + 8'd1;
  assign payload   = (phase == PH_ESC) ? (rx_byte ^ lped_pkg::ESC_XOR) : rx_byte;

  always_comb begin
    phase_next        = phase;
    expected_len_next = expected_len;
    byte_count_next   = byte_count;
    res               = '0;
    res.kind          = lped_pkg::KIND_DATA;
    res.frame_length  = expected_len;
    unique case (phase)
      PH_LEN: begin
        expected_len_next = rx_byte;
        byte_count_next   = 8'd0;
        if (rx_byte > max_len) begin
          phase_next       = PH_START;
          res.has_result   = 1'b1;
          res.kind         = lped_pkg::KIND_DROP;
          res.frame_length = rx_byte;
        end else if (rx_byte == 8'd0) begin
          phase_next = PH_END;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD, PH_ESC: begin
        if (phase == PH_PAYLOAD && rx_byte == lped_pkg::ESC_BYTE) begin
          phase_next = PH_ESC;
        end else begin
          byte_count_next = count_inc;
          phase_next      = (count_inc == expected_len) ? PH_END : PH_PAYLOAD;
          res.has_result  = 1'b1;
          res.kind        = lped_pkg::KIND_DATA;
          res.data        = payload;
          res.position    = byte_count;
        end
      end
      PH_END: begin
        if (rx_byte == lped_pkg::FLAG_BYTE) begin
          phase_next     = PH_START;
          res.has_result = 1'b1;
          res.kind       = lped_pkg::KIND_DONE;
        end
      end
      default: begin
        // PH_START and unused phase codes hunt for the start flag.
        if (rx_byte == lped_pkg::FLAG_BYTE) begin
          phase_next      = PH_LEN;
          byte_count_next = 8'd0;
        end else begin
          phase_next = PH_START;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      expected_len <= 8'd0;
      byte_count   <= 8'd0;
    end else if (step) begin
      phase        <= phase_next;
      expected_len <= expected_len_next;
      byte_count   <= byte_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/length_prefixed_escaped_deframer.sv =====
`default_nettype none
// A word accepted into the input register has its result, if any, loaded into the result
// register when the word moves on; the result can be taken from there.
// Throughput: one word per cycle; the input register takes a new word whenever it is
// empty or its word moves on, and its word moves on whenever the result register is
// empty or being drained.
// Reset (synchronous, active high) clears both registers, returns the framer to
// hunting for the start flag and sets max_len to 255.

module length_prefixed_escaped_deframer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      kind,
  output logic [7:0]      data,
  output logic [7:0]      position,
  output logic [7:0]      frame_length
);

  logic               s1_valid;
  logic [7:0]         s1_byte;
  logic               s1_adv;
  logic               out_free;
  logic [7:0]         max_len;
  lped_pkg::result_t  res;

  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  lped_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_adv),
    .rx_byte (s1_byte),
    .max_len (max_len),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= lped_pkg::MAX_LEN_RST;
    end else if (cfg_we) begin
      max_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  // A word that yields no result still moves on; it leaves the result fields alone and the result register empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_adv && res.has_result;
    end
    if (out_free && s1_adv && res.has_result) begin
      kind         <= res.kind;
      data         <= res.data;
      position     <= res.position;
      frame_length <= res.frame_length;
    end
  end

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == lped_pkg::KIND_DATA || kind == lped_pkg::KIND_DONE ||
                   kind == lped_pkg::KIND_DROP))
    else $error("illegal result kind");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == lped_pkg::KIND_DATA |-> position < frame_length)
    else $error("payload position beyond declared length");

  a_ctrl_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != lped_pkg::KIND_DATA |-> data == 8'd0 && position == 8'd0)
    else $error("data or position set on a control result");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |=> s1_valid && $stable(s1_byte))
    else $error("input register lost a word while the output was stalled");

endmodule

`default_nettype wire
